// File: hdl/blms_pkg.sv
`default_nettype none
package blms_pkg;

  // Item action codes.
  localparam logic [1:0] ACT_WR_POINT = 2'd0;
  localparam logic [1:0] ACT_WR_COUNT = 2'd1;
  localparam logic [1:0] ACT_RD_BLER  = 2'd2;
  localparam logic [1:0] ACT_SEL_MCS  = 2'd3;

  localparam int NUM_CLASSES = 5;
  localparam logic [16:0] BLER_ONE = 17'h10000;
  localparam logic [16:0] TARGET_RESET = 17'd6554;

  // RB count limits of the classes.
  localparam logic [6:0] RB_MAX = 7'd100;
  localparam logic [6:0] RB_C1  = 7'd3;
  localparam logic [6:0] RB_C2  = 7'd7;
  localparam logic [6:0] RB_C3  = 7'd20;
  localparam logic [2:0] CLASS_DEFAULT = 3'd4;

  // Divider operands handed from the sequencer.
  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [15:0] den;
  } div_req_t;

  // Maps an RB count to its curve class; out-of-range counts use the last class.
  function automatic logic [2:0] rb_class(input logic [6:0] rb);
    logic [2:0] c;
    if (rb == 7'd0 || rb > RB_MAX) c = CLASS_DEFAULT;
    else if (rb == 7'd1) c = 3'd0;
    else if (rb <= RB_C1) c = 3'd1;
    else if (rb <= RB_C2) c = 3'd2;
    else if (rb <= RB_C3) c = 3'd3;
    else c = CLASS_DEFAULT;
    return c;
  endfunction

  function automatic logic rb_bad(input logic [6:0] rb);
    return (rb == 7'd0) || (rb > RB_MAX);
  endfunction

endpackage
`default_nettype wire

// File: hdl/blms_divider.sv
`default_nettype none
module blms_divider
  import blms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire div_req_t    req,
  output logic             done,
  output logic [16:0]      quot
);

  // Restoring division, one quotient bit a cycle. The quotient is known to
  // fit 17 bits, so the upper numerator bits seed the remainder.
  logic [15:0] rem;
  logic [16:0] q;
  logic [15:0] den;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem, q[16]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd17;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num[32:17];
      q   <= req.num[16:0];
      den <= req.den;
    end else if (busy) begin
      rem <= fits ? 16'(trial - {1'b0, den}) : trial[15:0];
      q   <= {q[15:0], fits};
    end
  end

  assign quot = q;

endmodule
`default_nettype wire

// File: hdl/bler_curve_lookup_mcs_select_core.sv
// BLER read: a length check, then the last and first points, then a point scan
// and, where needed, an interpolation; an empty curve ends at the length check.
// MCS select repeats the lookup per MCS, up to NUM_MCS-1 times.
// One shared multiplier and a bit-serial divider do the arithmetic;
// one item is in work at a time.
// Reset (rst, synchronous) empties all curves and sets the target to 6554.
`default_nettype none
module bler_curve_lookup_mcs_select_core
  import blms_pkg::*;
#(
  parameter int NUM_MCS    = 16,
  parameter int MAX_POINTS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic [6:0]         rb_count,
  input  wire logic [2:0]         curve_class,
  input  wire logic [3:0]         mcs_number,
  input  wire logic [4:0]         point_index,
  input  wire logic signed [15:0] sinr_db,
  input  wire logic [16:0]        bler_value,
  input  wire logic [5:0]         point_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [16:0]             bler,
  output logic [3:0]              mcs_selected,
  output logic                    rb_error,
  output logic                    curve_error,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [16:0]        bler_target
);

  localparam int NUM_CURVES = NUM_CLASSES * NUM_MCS;
  localparam int CW         = $clog2(NUM_CURVES);
  localparam int PTW        = $clog2(MAX_POINTS);
  localparam int CNTW       = $clog2(MAX_POINTS + 1);
  localparam int MEM_DEPTH  = NUM_CURVES * (2 ** PTW);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_LEN_RD    = 4'd1;
  localparam logic [3:0] S_LEN_CHK   = 4'd2;
  localparam logic [3:0] S_LAST_RD   = 4'd3;
  localparam logic [3:0] S_LAST_CHK  = 4'd4;
  localparam logic [3:0] S_FIRST_RD  = 4'd5;
  localparam logic [3:0] S_FIRST_CHK = 4'd6;
  localparam logic [3:0] S_SCAN_RD   = 4'd7;
  localparam logic [3:0] S_SCAN_CHK  = 4'd8;
  localparam logic [3:0] S_MUL1      = 4'd9;
  localparam logic [3:0] S_MUL2      = 4'd10;
  localparam logic [3:0] S_ADD       = 4'd11;
  localparam logic [3:0] S_DIV       = 4'd12;
  localparam logic [3:0] S_LK_END    = 4'd13;
  localparam logic [3:0] S_DONE      = 4'd14;

  logic [3:0] state;
  logic       in_acc;

  // Configuration register.
  logic [16:0] tgt;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) tgt <= TARGET_RESET;
    else if (cfg_valid) tgt <= bler_target;
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Load addressing from the item fields.
  logic          ld_ok;
  logic          pt_ok;
  logic [CW-1:0] ld_curve;
  assign ld_ok = (int'(curve_class) < NUM_CLASSES) && (mcs_number != 4'd0)
                 && (int'(mcs_number) <= NUM_MCS);
  assign pt_ok = int'(point_index) < MAX_POINTS;
  assign ld_curve = CW'(int'(curve_class) * NUM_MCS + int'(mcs_number) - 1);

  // Item and lookup registers.
  logic [1:0]         act;
  logic signed [15:0] x;
  logic [2:0]         cls;
  logic [3:0]         cur_mcs;
  logic [CNTW-1:0]    n_pts;
  logic [PTW-1:0]     k;
  logic signed [15:0] s0, s1;
  logic [16:0]        b0, b1;
  logic [32:0]        prod, acc;
  logic [16:0]        res;
  logic               lk_empty;
  logic [16:0]        r_bler;
  logic [3:0]         r_sel;
  logic               r_rberr, r_cerr;

  logic          mcs_ok;
  logic [CW-1:0] cur_curve;
  assign mcs_ok = (cur_mcs != 4'd0) && (int'(cur_mcs) <= NUM_MCS);
  assign cur_curve = CW'(int'(cls) * NUM_MCS + int'(cur_mcs) - 1);

  // Point count store with per-curve valid bits cleared by reset.
  logic [CNTW-1:0]       len_mem [0:NUM_CURVES-1];
  logic [NUM_CURVES-1:0] len_vld;
  logic [CNTW-1:0]       len_rd;
  logic                  lv_rd;
  logic [CNTW-1:0]       cnt_clamp;
  assign cnt_clamp = (int'(point_count) > MAX_POINTS) ? CNTW'(MAX_POINTS)
                                                      : CNTW'(point_count);

  always_ff @(posedge clk) begin
    if (in_acc && action == ACT_WR_COUNT && ld_ok) len_mem[ld_curve] <= cnt_clamp;
    len_rd <= len_mem[cur_curve];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_vld <= '0;
      lv_rd   <= 1'b0;
    end else begin
      if (in_acc && action == ACT_WR_COUNT && ld_ok) len_vld[ld_curve] <= 1'b1;
      lv_rd <= len_vld[cur_curve];
    end
  end

  // Curve point memories, written on loads and read by the scan at its own address.
  logic signed [15:0] sinr_mem [0:MEM_DEPTH-1];
  logic [16:0]        bler_mem [0:MEM_DEPTH-1];
  logic signed [15:0] s_rd;
  logic [16:0]        b_rd;
  logic [16:0]        bv_clamp;
  assign bv_clamp = (bler_value > BLER_ONE) ? BLER_ONE : bler_value;

  always_ff @(posedge clk) begin
    if (in_acc && action == ACT_WR_POINT && ld_ok && pt_ok) begin
      sinr_mem[{ld_curve, PTW'(point_index)}] <= sinr_db;
      bler_mem[{ld_curve, PTW'(point_index)}] <= bv_clamp;
    end
    s_rd <= sinr_mem[{cur_curve, k}];
    b_rd <= bler_mem[{cur_curve, k}];
  end

  // Shared multiplier over the two interpolation weights.
  logic [15:0] mul_a;
  logic [16:0] mul_b;
  logic [16:0] d_hi, d_lo, d_seg;
  assign d_hi  = 17'({s1[15], s1} - {x[15], x});
  assign d_lo  = 17'({x[15], x} - {s0[15], s0});
  assign d_seg = 17'({s1[15], s1} - {s0[15], s0});
  assign mul_a = (state == S_MUL1) ? d_hi[15:0] : d_lo[15:0];
  assign mul_b = (state == S_MUL1) ? b0 : b1;

  div_req_t    dreq;
  logic        div_done;
  logic [16:0] div_q;
  assign dreq.start = (state == S_ADD);
  assign dreq.num   = acc + prod;
  assign dreq.den   = d_seg[15:0];

  blms_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quot (div_q)
  );

  logic [CNTW-1:0] n_now;
  assign n_now = lv_rd ? len_rd : '0;

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_acc) begin
          state <= (action inside {ACT_RD_BLER, ACT_SEL_MCS}) ? S_LEN_RD : S_DONE;
        end
        S_LEN_RD:  state <= S_LEN_CHK;
        S_LEN_CHK: state <= (!mcs_ok || n_now == '0) ? S_LK_END : S_LAST_RD;
        S_LAST_RD: state <= S_LAST_CHK;
        S_LAST_CHK: state <= (x > s_rd) ? S_LK_END : S_FIRST_RD;
        S_FIRST_RD: state <= S_FIRST_CHK;
        S_FIRST_CHK: begin
          if (x < s_rd || n_pts == CNTW'(1)) state <= S_LK_END;
          else state <= S_SCAN_RD;
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (x <= s_rd || CNTW'(k) == n_pts - CNTW'(1)) begin
            state <= (s_rd == s0) ? S_LK_END : S_MUL1;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_ADD;
        S_ADD:  state <= S_DIV;
        S_DIV:  if (div_done) state <= S_LK_END;
        S_LK_END: begin
          if (act == ACT_SEL_MCS && res <= tgt && int'(cur_mcs) < NUM_MCS - 1)
            state <= S_LEN_RD;
          else
            state <= S_DONE;
        end
        S_DONE: if (!out_valid || !out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the lookup.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        act      <= action;
        x        <= sinr_db;
        cls      <= rb_class(rb_count);
        cur_mcs  <= (action == ACT_SEL_MCS) ? 4'd1 : mcs_number;
        r_bler   <= '0;
        r_sel    <= '0;
        r_cerr   <= 1'b0;
        r_rberr  <= (action inside {ACT_RD_BLER, ACT_SEL_MCS}) ? rb_bad(rb_count) : 1'b0;
        k        <= '0;
      end
      S_LEN_CHK: begin
        n_pts    <= n_now;
        k        <= PTW'(n_now - CNTW'(1));
        lk_empty <= !mcs_ok || n_now == '0;
        res      <= BLER_ONE;
      end
      S_LAST_CHK: begin
        res <= '0;
        k   <= '0;
      end
      S_FIRST_CHK: begin
        res <= (x < s_rd) ? BLER_ONE : b_rd;
        s0  <= s_rd;
        b0  <= b_rd;
        k   <= PTW'(1);
      end
      S_SCAN_CHK: begin
        res <= b_rd;
        if (x <= s_rd || CNTW'(k) == n_pts - CNTW'(1)) begin
          s1 <= s_rd;
          b1 <= b_rd;
        end else begin
          s0 <= s_rd;
          b0 <= b_rd;
          k  <= k + PTW'(1);
        end
      end
      S_MUL1: prod <= {17'd0, mul_a} * {16'd0, mul_b};
      S_MUL2: begin
        acc  <= prod;
        prod <= {17'd0, mul_a} * {16'd0, mul_b};
      end
      S_DIV: if (div_done) res <= div_q;
      S_LK_END: begin
        if (act == ACT_RD_BLER) begin
          r_bler <= res;
          r_cerr <= lk_empty;
        end else begin
          if (lk_empty) r_cerr <= 1'b1;
          if (res <= tgt) r_sel <= cur_mcs;
          cur_mcs <= cur_mcs + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // Output register; it holds a finished item while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      bler         <= r_bler;
      mcs_selected <= r_sel;
      rb_error     <= r_rberr;
      curve_error  <= r_cerr;
    end
  end

endmodule
`default_nettype wire

// File: hdl/blms_checker.sv
`default_nettype none
module blms_checker
  import blms_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [16:0]        bler,
  input wire logic [3:0]         mcs_selected,
  input wire logic               rb_error,
  input wire logic               curve_error
);

  // The block takes one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while previous item in work");

  // A result waiting on the sink keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(bler)
      && $stable(mcs_selected) && $stable(rb_error) && $stable(curve_error)))
    else $error("stalled result changed");

  // A BLER answer and an MCS choice never come from the same item.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bler == '0 || mcs_selected == '0))
    else $error("result carries both BLER and MCS");

  // Interpolated BLER stays within 1.0.
  a_bler_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bler <= BLER_ONE)
    else $error("BLER above one");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bler_curve_lookup_mcs_select_core blms_checker u_blms_checker (.*);
`default_nettype wire

// File: bench/bler_curve_lookup_mcs_select_core_test.sv
`default_nettype none
module bler_curve_lookup_mcs_select_core_test;
  import blms_pkg::*;

  localparam int MCS_COUNT   = 16;
  localparam int POINT_SLOTS = 32;
  localparam int CURVE_COUNT = NUM_CLASSES * MCS_COUNT;

  typedef struct packed {
    logic [1:0]         action;
    logic [6:0]         rb_count;
    logic [2:0]         curve_class;
    logic [3:0]         mcs_number;
    logic [4:0]         point_index;
    logic signed [15:0] sinr_db;
    logic [16:0]        bler_value;
    logic [5:0]         point_count;
  } lookup_req_t;

  typedef struct packed {
    logic [16:0] bler;
    logic [3:0]  mcs_selected;
    logic        rb_error;
    logic        curve_error;
  } lookup_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_WR_POINT;
  logic [6:0] rb_count = '0;
  logic [2:0] curve_class = '0;
  logic [3:0] mcs_number = '0;
  logic [4:0] point_index = '0;
  logic signed [15:0] sinr_db = '0;
  logic [16:0] bler_value = '0;
  logic [5:0] point_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] bler;
  logic [3:0] mcs_selected;
  logic rb_error;
  logic curve_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [16:0] bler_target = TARGET_RESET;

  bler_curve_lookup_mcs_select_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .rb_count(rb_count), .curve_class(curve_class),
    .mcs_number(mcs_number), .point_index(point_index), .sinr_db(sinr_db),
    .bler_value(bler_value), .point_count(point_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .bler(bler), .mcs_selected(mcs_selected), .rb_error(rb_error),
    .curve_error(curve_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .bler_target(bler_target)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted curve memory, target and the pending expected results.
  int          pred_sinr [CURVE_COUNT*POINT_SLOTS];
  int          pred_bler [CURVE_COUNT*POINT_SLOTS];
  int          pred_len [CURVE_COUNT];
  int          written_prefix [CURVE_COUNT];
  logic [16:0] pred_target = TARGET_RESET;
  lookup_rsp_t pending_rsp [$];

  int  error_count = 0;
  int  items_sent = 0;
  int  reads_sent = 0;
  int  selects_sent = 0;
  int  rsp_checked = 0;
  bit  quiet = 1'b0;
  int  hold_cycles = 0;

  // Interpolated BLER of one curve at one SINR; flags an empty curve.
  function automatic int curve_bler_at(int cls, int mcs, int x, output bit empty);
    int base, n, k;
    longint s0, s1, b0, b1, num, den;
    empty = 1'b0;
    if (mcs == 0 || mcs > MCS_COUNT) begin
      empty = 1'b1;
      return 65536;
    end
    base = cls * MCS_COUNT + mcs - 1;
    n = pred_len[base];
    if (n == 0) begin
      empty = 1'b1;
      return 65536;
    end
    base = base * POINT_SLOTS;
    if (x > pred_sinr[base + n - 1]) return 0;
    if (x < pred_sinr[base]) return 65536;
    if (n == 1) return pred_bler[base];
    for (k = 1; k < n - 1; k++) if (x <= pred_sinr[base + k]) break;
    s0 = pred_sinr[base + k - 1];
    s1 = pred_sinr[base + k];
    b0 = pred_bler[base + k - 1];
    b1 = pred_bler[base + k];
    if (s1 == s0) return int'(b1);
    den = s1 - s0;
    num = (s1 - x) * b0 + (x - s0) * b1;
    return int'(num / den);
  endfunction

  // Applies one accepted item to the predicted state and returns its result.
  function automatic lookup_rsp_t predict_lookup(lookup_req_t it);
    lookup_rsp_t r;
    int cls, curve, m, b;
    bit addr_ok, empty;
    r = '0;
    addr_ok = it.curve_class < NUM_CLASSES && it.mcs_number >= 1;
    curve = it.curve_class * MCS_COUNT + it.mcs_number - 1;
    if (it.rb_count == 0 || it.rb_count > 100) cls = 4;
    else if (it.rb_count == 1) cls = 0;
    else if (it.rb_count <= 3) cls = 1;
    else if (it.rb_count <= 7) cls = 2;
    else if (it.rb_count <= 20) cls = 3;
    else cls = 4;
    case (it.action)
      ACT_WR_POINT: begin
        if (addr_ok) begin
          pred_sinr[curve*POINT_SLOTS + it.point_index] = it.sinr_db;
          pred_bler[curve*POINT_SLOTS + it.point_index] =
            (it.bler_value > 65536) ? 65536 : it.bler_value;
        end
      end
      ACT_WR_COUNT: begin
        if (addr_ok)
          pred_len[curve] = (it.point_count > POINT_SLOTS) ? POINT_SLOTS : it.point_count;
      end
      ACT_RD_BLER: begin
        r.rb_error = (it.rb_count == 0 || it.rb_count > 100);
        r.bler = 17'(curve_bler_at(cls, it.mcs_number, it.sinr_db, empty));
        r.curve_error = empty;
      end
      default: begin
        r.rb_error = (it.rb_count == 0 || it.rb_count > 100);
        for (m = 1; m < MCS_COUNT; m++) begin
          b = curve_bler_at(cls, m, it.sinr_db, empty);
          if (empty) r.curve_error = 1'b1;
          if (b <= pred_target) r.mcs_selected = 4'(m);
          else break;
        end
      end
    endcase
    return r;
  endfunction

  // Offers one item, waits for its acceptance and records the expectation.
  task automatic send_item(lookup_req_t it);
    int gap;
    gap = 0;
    if (!quiet) while ($urandom_range(99) < 21) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= it.action;
    rb_count <= it.rb_count;
    curve_class <= it.curve_class;
    mcs_number <= it.mcs_number;
    point_index <= it.point_index;
    sinr_db <= it.sinr_db;
    bler_value <= it.bler_value;
    point_count <= it.point_count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rsp.push_back(predict_lookup(it));
    items_sent++;
    if (it.action == ACT_RD_BLER) reads_sent++;
    if (it.action == ACT_SEL_MCS) selects_sent++;
  endtask

  task automatic send_point(int cls, int mcs, int idx, int s, int b);
    lookup_req_t it;
    it = '0;
    it.action = ACT_WR_POINT;
    it.rb_count = 7'($urandom);
    it.point_count = 6'($urandom);
    it.curve_class = 3'(cls);
    it.mcs_number = 4'(mcs);
    it.point_index = 5'(idx);
    it.sinr_db = 16'(s);
    it.bler_value = 17'(b);
    send_item(it);
    if (cls < NUM_CLASSES && mcs >= 1 && idx == written_prefix[cls*MCS_COUNT + mcs - 1])
      written_prefix[cls*MCS_COUNT + mcs - 1] = idx + 1;
  endtask

  task automatic send_count(int cls, int mcs, int cnt);
    lookup_req_t it;
    it = '0;
    it.action = ACT_WR_COUNT;
    it.rb_count = 7'($urandom);
    it.sinr_db = 16'($urandom);
    it.curve_class = 3'(cls);
    it.mcs_number = 4'(mcs);
    it.point_count = 6'(cnt);
    send_item(it);
  endtask

  task automatic send_query(logic [1:0] act, int rb, int mcs, int s);
    lookup_req_t it;
    it = '0;
    it.action = act;
    it.rb_count = 7'(rb);
    it.mcs_number = 4'(mcs);
    it.sinr_db = 16'(s);
    it.curve_class = 3'($urandom);
    it.point_index = 5'($urandom);
    it.bler_value = 17'($urandom);
    send_item(it);
  endtask

  // Loads a curve: non-falling SINR, mostly falling BLER, then its count.
  task automatic load_curve(int cls, int mcs, int n);
    int s, b, i, maxstep;
    s = $urandom_range(65535) - 32768;
    if (s > 32767 - n) s = 32767 - n * 200;
    if (s < -32768) s = -32768;
    b = 65536;
    for (i = 0; i < n; i++) begin
      send_point(cls, mcs, i, s, ($urandom_range(19) == 0) ? $urandom_range(131071) : b);
      maxstep = (32767 - s) / (n - i);
      if (maxstep > 3000) maxstep = 3000;
      if ($urandom_range(5) != 0 && maxstep >= 1) s += $urandom_range(maxstep, 1);
      b -= $urandom_range(b);
    end
    send_count(cls, mcs, (n == POINT_SLOTS && $urandom_range(1)) ? $urandom_range(63, 33) : n);
  endtask

  // Writes the target register while the block is idle.
  task automatic write_target(logic [16:0] value);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    bler_target <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pred_target = value;
  endtask

  // Compares each accepted result with the oldest expectation and sets the stall.
  always @(posedge clk) begin
    lookup_rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      rsp_checked++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result bler=%0d mcs=%0d rb_err=%0b curve_err=%0b",
                 $time, bler, mcs_selected, rb_error, curve_error);
        error_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (bler !== want.bler) begin
          $display("%0t: bler expected %0d actual %0d", $time, want.bler, bler);
          error_count++;
        end
        if (mcs_selected !== want.mcs_selected) begin
          $display("%0t: mcs_selected expected %0d actual %0d", $time,
                   want.mcs_selected, mcs_selected);
          error_count++;
        end
        if (rb_error !== want.rb_error) begin
          $display("%0t: rb_error expected %0b actual %0b", $time, want.rb_error, rb_error);
          error_count++;
        end
        if (curve_error !== want.curve_error) begin
          $display("%0t: curve_error expected %0b actual %0b", $time,
                   want.curve_error, curve_error);
          error_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 21);
    end
  end

  // Short curves that hit the corner cases, then queries against them.
  task automatic test_directed;
    write_target(17'd0);
    send_point(0, 1, 0, 100, 30000);
    send_count(0, 1, 1);
    send_point(1, 2, 0, -32768, 65536);
    send_point(1, 2, 1, 0, 131071);
    send_point(1, 2, 2, 0, 500);
    send_point(1, 2, 3, 32767, 0);
    send_count(1, 2, 4);
    send_point(5, 1, 0, 7, 7);
    send_point(2, 0, 0, 7, 7);
    send_count(7, 3, 2);
    send_count(3, 0, 5);
    send_query(ACT_RD_BLER, 1, 1, 100);
    send_query(ACT_RD_BLER, 1, 1, 99);
    send_query(ACT_RD_BLER, 1, 1, 101);
    send_query(ACT_RD_BLER, 3, 2, 0);
    send_query(ACT_RD_BLER, 2, 2, -32768);
    send_query(ACT_RD_BLER, 2, 2, 32767);
    send_query(ACT_RD_BLER, 2, 2, 1234);
    send_query(ACT_RD_BLER, 0, 1, 5);
    send_query(ACT_RD_BLER, 127, 1, 5);
    send_query(ACT_RD_BLER, 1, 0, 5);
    send_query(ACT_SEL_MCS, 1, 3, 32767);
    send_query(ACT_SEL_MCS, 101, 3, -32768);
    write_target(17'h1FFFF);
    send_query(ACT_SEL_MCS, 1, 0, 150);
  endtask

  // Fills one class with curves for MCS 1 to MCS_COUNT-1 so selects scan deep.
  task automatic test_fill_class(int cls);
    int m;
    for (m = 1; m < MCS_COUNT; m++) load_curve(cls, m, $urandom_range(5, 1));
  endtask

  // Mixed random traffic: mostly curve loads and queries, some noise.
  task automatic test_random(int total);
    int pick, cls, mcs, c;
    while (items_sent < total) begin
      pick = $urandom_range(99);
      cls = $urandom_range(4);
      mcs = $urandom_range(15, 1);
      c = cls * MCS_COUNT + mcs - 1;
      if (pick < 20) begin
        load_curve(cls, mcs, ($urandom_range(15) == 0) ? POINT_SLOTS : $urandom_range(8, 1));
      end else if (pick < 28) begin
        send_count(cls, mcs, (written_prefix[c] == POINT_SLOTS) ?
                   $urandom_range(63) : $urandom_range(written_prefix[c]));
      end else if (pick < 33) begin
        if ($urandom_range(1))
          send_point($urandom_range(7, 5), $urandom_range(15), $urandom_range(31),
                     $urandom_range(65535), $urandom_range(131071));
        else if ($urandom_range(1))
          send_count($urandom_range(7, 5), mcs, $urandom_range(63));
        else
          send_count(cls, 0, $urandom_range(63));
      end else if (pick < 65) begin
        send_query(ACT_RD_BLER, $urandom_range(127), $urandom_range(15),
                   $urandom_range(65535));
      end else begin
        send_query(ACT_SEL_MCS, $urandom_range(127), $urandom_range(15),
                   $urandom_range(1) ? $urandom_range(65535) : $urandom_range(8000) - 4000);
      end
    end
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_backpressure;
    int i;
    hold_cycles = 400;
    for (i = 0; i < 6; i++)
      send_query(ACT_RD_BLER, $urandom_range(100, 1), $urandom_range(15, 1),
                 $urandom_range(65535));
  endtask

  // A stretch with no idling on either side.
  task automatic test_quiet_stretch;
    int i;
    quiet = 1'b1;
    for (i = 0; i < 40; i++)
      send_query($urandom_range(1) ? ACT_RD_BLER : ACT_SEL_MCS, $urandom_range(127),
                 $urandom_range(15), $urandom_range(65535));
    quiet = 1'b0;
  endtask

  initial begin
    int waited;
    foreach (pred_len[i]) begin
      pred_len[i] = 0;
      written_prefix[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed;
    write_target(17'd6554);
    test_fill_class(4);
    test_fill_class(3);
    test_random(450);
    write_target(17'd65536);
    test_backpressure;
    test_quiet_stretch;
    write_target(17'($urandom_range(65535)));
    test_random(850);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_rsp.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    $display("Covered %0d items: %0d BLER reads, %0d MCS selects, %0d results checked.",
             items_sent, reads_sent, selects_sent, rsp_checked);
    $display("Target settings included 0, 1.0 and the all-ones register value.");
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Overall time limit for the run.
  initial begin
    #100000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
hdl/blms_pkg.sv
hdl/blms_divider.sv
hdl/bler_curve_lookup_mcs_select_core.sv
hdl/blms_checker.sv
bench/bler_curve_lookup_mcs_select_core_test.sv
